// ----- rtl/unicycle_pose_integrator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the unicycle pose integrator
// Same-cycle and next-cycle implication checks, gated by the active-low reset.
// ----------------------------------------------------------------------------
`ifndef UNICYCLE_POSE_INTEGRATOR_UNIT_MACROS_SVH
`define UNICYCLE_POSE_INTEGRATOR_UNIT_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define UPI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds -> cons holds in the next cycle
`define UPI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/upi_pkg.sv -----
// ----------------------------------------------------------------------------
// upi_pkg
// Types, constants and tables of the unicycle pose integrator.
// ----------------------------------------------------------------------------
package upi_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int AtanLen = 30;
    localparam int CordicRun = (CORDIC_ITERATIONS > AtanLen) ? AtanLen : CORDIC_ITERATIONS;

    // Q2.30 / Q16.16 constants
    localparam logic signed [34:0] CordicGain = 35'sd652032874;
    localparam logic signed [34:0] PiQ30      = 35'sd3373259426;
    localparam logic signed [34:0] HalfPiQ30  = 35'sd1686629713;
    localparam logic [35:0]        TwoPiQ16   = 36'd411775;
    localparam logic signed [37:0] WrapLow    = 38'sd205888;
    localparam logic signed [37:0] WrapBias   = 38'sd205888 + (38'sd411775 <<< 15);

    localparam logic [15:0] TimeStepReset = 16'd1966;
    localparam logic [30:0] RadiusReset   = 31'd65536;

    typedef enum logic [1:0] {
        REG_TIME_STEP     = 2'd0,
        REG_OFFSET_RADIUS = 2'd1
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CSET,
        S_CITER,
        S_CDONE,
        S_MX,
        S_MY,
        S_IX,
        S_IY,
        S_IH,
        S_WSET,
        S_WRAP,
        S_WFIN,
        S_PX,
        S_PY,
        S_OUT
    } t_state;

    function automatic logic [29:0] f_atan(input logic [4:0] i);
        logic [29:0] r;
        begin
            case (i)
                5'd0:  r = 30'd843314857;
                5'd1:  r = 30'd497837830;
                5'd2:  r = 30'd263043837;
                5'd3:  r = 30'd133525159;
                5'd4:  r = 30'd67021687;
                5'd5:  r = 30'd33543516;
                5'd6:  r = 30'd16775851;
                5'd7:  r = 30'd8388437;
                5'd8:  r = 30'd4194283;
                5'd9:  r = 30'd2097149;
                5'd10: r = 30'd1048576;
                5'd11: r = 30'd524288;
                5'd12: r = 30'd262144;
                5'd13: r = 30'd131072;
                5'd14: r = 30'd65536;
                5'd15: r = 30'd32768;
                5'd16: r = 30'd16384;
                5'd17: r = 30'd8192;
                5'd18: r = 30'd4096;
                5'd19: r = 30'd2048;
                5'd20: r = 30'd1024;
                5'd21: r = 30'd512;
                5'd22: r = 30'd256;
                5'd23: r = 30'd128;
                5'd24: r = 30'd64;
                5'd25: r = 30'd32;
                5'd26: r = 30'd16;
                5'd27: r = 30'd8;
                5'd28: r = 30'd4;
                5'd29: r = 30'd2;
                default: r = 30'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        begin
            if (v > 38'sd2147483647) r = 32'sh7FFFFFFF;
            else if (v < -38'sd2147483648) r = 32'sh80000000;
            else r = v[31:0];
            return r;
        end
    endfunction

endpackage

// ----- rtl/unicycle_pose_integrator_unit.sv -----
// ----------------------------------------------------------------------------
// unicycle_pose_integrator_unit
// Trapezoidal unicycle odometry in Q16.16 with a shared CORDIC and multiplier.
// ----------------------------------------------------------------------------
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+-----------------------------------
//  in      | i_in_valid   | o_in_stall   | i_speed_linear, i_speed_angular
//  out     | o_out_valid  | i_out_stall  | o_pose_*, o_point_x, o_point_y
//  cfg     | i_cfg_we     | -            | i_cfg_index, i_cfg_data
//
//  Work on one beat runs from acceptance to the result register as two passes
//  of the single CORDIC stage, seven products on the one multiplier and a
//  heading wrap of 16 compare-subtract steps.
//  Only one beat is in work; the input stalls until the result is loaded.
//  A held result stalls the last step, not the computation before it.
//  Synchronous reset clears pose, last rates and registers to defaults.
// ----------------------------------------------------------------------------
`include "unicycle_pose_integrator_unit_macros.svh"

module unicycle_pose_integrator_unit
    import upi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_speed_linear,
    input  logic signed [31:0] i_speed_angular,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pose_x,
    output logic signed [31:0] o_pose_y,
    output logic signed [18:0] o_pose_heading,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y
);

    t_state r_state, n_state;

    logic [15:0]        r_ts;
    logic [30:0]        r_rad;
    logic signed [31:0] r_v, r_w;
    logic signed [31:0] r_px, r_py, r_lrx, r_lry, r_lrw, r_rx, r_ry, r_ptx;
    logic signed [18:0] r_head;
    logic               r_pass, r_flip, r_out_valid;
    logic signed [33:0] r_cx, r_cy;
    logic signed [34:0] r_cz;
    logic [4:0]         r_it;
    logic signed [19:0] r_cos, r_sin;
    logic [35:0]        r_wrap;
    logic [3:0]         r_k;
    logic signed [53:0] r_prod;

    logic signed [32:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [53:0] prod;
    logic signed [37:0] rnd16;
    logic signed [36:0] inc17;
    logic signed [34:0] z0;
    logic signed [33:0] dx, dy, xf, yf;
    logic signed [34:0] atan_e;
    logic [35:0]        wstep;
    logic               in_acc, out_load, head_ok;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_OUT) && !(r_out_valid && i_out_stall);
    assign head_ok  = (r_head >= -19'sd205888) && (r_head <= 19'sd205886);

    // ---- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CSET;
            S_CSET:  n_state = S_CITER;
            S_CITER: if (r_it == 5'(CordicRun - 1)) n_state = S_CDONE;
            S_CDONE: n_state = r_pass ? S_PX : S_MX;
            S_MX:    n_state = S_MY;
            S_MY:    n_state = S_IX;
            S_IX:    n_state = S_IY;
            S_IY:    n_state = S_IH;
            S_IH:    n_state = S_WSET;
            S_WSET:  n_state = S_WRAP;
            S_WRAP:  if (r_k == 4'd0) n_state = S_WFIN;
            S_WFIN:  n_state = S_CSET;
            S_PX:    n_state = S_PY;
            S_PY:    n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---- outputs
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = r_out_valid;
    end

    // ---- shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MX: begin mul_a = 33'(r_v); mul_b = 21'(r_cos); end
            S_MY: begin mul_a = 33'(r_v); mul_b = 21'(r_sin); end
            S_IX: begin mul_a = 33'(r_rx) + 33'(r_lrx); mul_b = {5'd0, r_ts}; end
            S_IY: begin mul_a = 33'(r_ry) + 33'(r_lry); mul_b = {5'd0, r_ts}; end
            S_IH: begin mul_a = 33'(r_w) + 33'(r_lrw); mul_b = {5'd0, r_ts}; end
            S_PX: begin mul_a = {2'b00, r_rad}; mul_b = 21'(r_cos); end
            S_PY: begin mul_a = {2'b00, r_rad}; mul_b = 21'(r_sin); end
            // keeps the last product while the result waits
            S_OUT: begin mul_a = {2'b00, r_rad}; mul_b = 21'(r_sin); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        prod   = 54'(mul_a) * 54'(mul_b);
        rnd16  = 38'((r_prod + 54'sd32768) >>> 16);
        inc17  = 37'((r_prod + 54'sd65536) >>> 17);
        // heading to Q2.30, folded into [-pi/2, pi/2]
        z0     = 35'(r_head) <<< 14;
        dx     = r_cy >>> r_it;
        dy     = r_cx >>> r_it;
        atan_e = 35'($signed({1'b0, f_atan(r_it)}));
        xf     = r_flip ? -r_cx : r_cx;
        yf     = r_flip ? -r_cy : r_cy;
        wstep  = TwoPiQ16 << r_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ts        <= TimeStepReset;
            r_rad       <= RadiusReset;
            r_px        <= '0;
            r_py        <= '0;
            r_head      <= '0;
            r_lrx       <= '0;
            r_lry       <= '0;
            r_lrw       <= '0;
            r_out_valid <= 1'b0;
            r_pass      <= 1'b0;
            r_it        <= '0;
            r_k         <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TIME_STEP:     r_ts  <= i_cfg_data[15:0];
                    REG_OFFSET_RADIUS: r_rad <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            r_prod <= prod;
            case (r_state)
                S_IDLE: begin
                    r_v    <= i_speed_linear;
                    r_w    <= i_speed_angular;
                    r_pass <= 1'b0;
                end
                S_CSET: begin
                    r_cx <= 34'(CordicGain);
                    r_cy <= '0;
                    r_it <= '0;
                    if (z0 > HalfPiQ30) begin
                        r_cz <= z0 - PiQ30; r_flip <= 1'b1;
                    end else if (z0 < -HalfPiQ30) begin
                        r_cz <= z0 + PiQ30; r_flip <= 1'b1;
                    end else begin
                        r_cz <= z0; r_flip <= 1'b0;
                    end
                end
                S_CITER: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - dx; r_cy <= r_cy + dy; r_cz <= r_cz - atan_e;
                    end else begin
                        r_cx <= r_cx + dx; r_cy <= r_cy - dy; r_cz <= r_cz + atan_e;
                    end
                    r_it <= r_it + 5'd1;
                end
                S_CDONE: begin
                    r_cos <= 20'((xf + 34'sd8192) >>> 14);
                    r_sin <= 20'((yf + 34'sd8192) >>> 14);
                end
                S_MY: r_rx <= f_sat32(rnd16);
                S_IX: r_ry <= f_sat32(rnd16);
                S_IY: r_px <= f_sat32(38'(r_px) + 38'(inc17));
                S_IH: r_py <= f_sat32(38'(r_py) + 38'(inc17));
                S_WSET: begin
                    // biased positive so the wrap is a plain unsigned remainder
                    r_wrap <= 36'(38'(r_head) + 38'(inc17) + WrapBias);
                    r_lrx  <= r_rx;
                    r_lry  <= r_ry;
                    r_lrw  <= r_w;
                    r_k    <= 4'd15;
                end
                S_WRAP: begin
                    if (r_wrap >= wstep) r_wrap <= r_wrap - wstep;
                    r_k <= r_k - 4'd1;
                end
                S_WFIN: begin
                    r_head <= 19'(38'(r_wrap) - WrapLow);
                    r_pass <= 1'b1;
                end
                S_PY: r_ptx <= f_sat32(38'(r_px) + rnd16);
                S_OUT: begin
                    if (out_load) begin
                        o_pose_x       <= r_px;
                        o_pose_y       <= r_py;
                        o_pose_heading <= r_head;
                        o_point_x      <= r_ptx;
                        o_point_y      <= f_sat32(38'(r_py) + rnd16);
                    end
                end
                default: ;
            endcase
        end
    end

    `UPI_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_state == S_CSET, "no start")
    `UPI_ASSERT_IMP(a_iter_bound, i_clk, i_rst_n, r_state == S_CITER, r_it < 5'(CordicRun), "overrun")
    `UPI_ASSERT_NXT(a_load_valid, i_clk, i_rst_n, out_load, r_out_valid, "result lost")
    `UPI_ASSERT_IMP(a_head_range, i_clk, i_rst_n, 1'b1, head_ok, "heading out of range")

endmodule
